// ===== hdl/dag_pkg.sv =====
// dag_pkg: shared types and constants for the detection anchor generator
// no dependencies
`default_nettype none
package dag_pkg;
	localparam int BASE_W = 11;
	localparam int RATIO_W = 12;
	localparam int SCALE_W = 16;
	localparam int COORD_W = 32;
	localparam int BOXNUM_W = 4;
	localparam int QUOT_W = 46;
	localparam int ROOT_W = 23;
	localparam int WID_W = 15;
	localparam int HGT_W = 19;

	localparam logic [2:0] REG_RATIO_COUNT = 3'd0;
	localparam logic [2:0] REG_SCALE_COUNT = 3'd1;
	localparam logic [2:0] REG_RATIO_A = 3'd2;
	localparam logic [2:0] REG_RATIO_B = 3'd3;
	localparam logic [2:0] REG_RATIO_C = 3'd4;
	localparam logic [2:0] REG_SCALE_A = 3'd5;
	localparam logic [2:0] REG_SCALE_B = 3'd6;
	localparam logic [2:0] REG_SCALE_C = 3'd7;

	typedef struct packed {
		logic load;
		logic div_start;
		logic sqrt_start;
		logic size_latch;
		logic emit;
	} dag_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic mul_done;
	} dag_sts_t;
endpackage
`default_nettype wire

// ===== hdl/dag_datapath.sv =====
// dag_datapath: shared iterative divider and square root, multiplier, box corners
// depends on dag_pkg
`default_nettype none
module dag_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire dag_pkg::dag_cmd_t cmd,
	output dag_pkg::dag_sts_t sts,
	input wire logic [dag_pkg::BASE_W-1:0] base_q,
	input wire logic [dag_pkg::RATIO_W-1:0] ratio,
	input wire logic [dag_pkg::SCALE_W-1:0] scale,
	output logic [dag_pkg::COORD_W-1:0] left,
	output logic [dag_pkg::COORD_W-1:0] top,
	output logic [dag_pkg::COORD_W-1:0] right,
	output logic [dag_pkg::COORD_W-1:0] bottom
);
	import dag_pkg::*;

	logic [QUOT_W-1:0] num_q, quot_q, rem_q;
	logic [5:0] cnt_q;
	logic [1:0] mode_q;
	logic [QUOT_W+1:0] rv_q, rres_q;
	logic [QUOT_W+1:0] rbit_q;
	logic [WID_W-1:0] w_q;
	logic [HGT_W-1:0] h_q;
	logic [1:0] mstep_q;
	logic [WID_W+SCALE_W-1:0] px_q;
	logic [HGT_W+SCALE_W-1:0] py_q;
	logic [RATIO_W-1:0] r_eff;
	logic [QUOT_W:0] rem_sh;
	logic [QUOT_W+1:0] trial;
	logic [WID_W+RATIO_W:0] wr;
	logic signed [36:0] cen, hx, hy;

	assign r_eff = (ratio == '0) ? RATIO_W'(1) : ratio;
	assign rem_sh = {rem_q, num_q[QUOT_W-1]};
	assign trial = rres_q + rbit_q;
	assign wr = (WID_W+RATIO_W+1)'(w_q) * (WID_W+RATIO_W+1)'(r_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			cnt_q <= '0;
			mstep_q <= '0;
		end else begin
			if (cmd.div_start) begin
				mode_q <= 2'd1;
				cnt_q <= 6'(QUOT_W);
			end else if (cmd.sqrt_start) begin
				mode_q <= 2'd2;
				cnt_q <= 6'(QUOT_W/2 + 1);
			end else if (mode_q != 2'd0) begin
				if (cnt_q == 6'd1) mode_q <= 2'd0;
				cnt_q <= cnt_q - 6'd1;
			end
			if (cmd.size_latch) mstep_q <= 2'd1;
			else if (mstep_q != 2'd0) mstep_q <= mstep_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q <= QUOT_W'({22'(base_q) * 22'(base_q), 24'd0});
			rem_q <= '0;
			quot_q <= '0;
		end else if (cmd.sqrt_start) begin
			rv_q <= (QUOT_W+2)'(quot_q);
			rres_q <= '0;
			rbit_q <= (QUOT_W+2)'(1) << QUOT_W;
		end else if (mode_q == 2'd1) begin
			num_q <= num_q << 1;
			if (rem_sh >= (QUOT_W+1)'(r_eff)) begin
				rem_q <= QUOT_W'(rem_sh - (QUOT_W+1)'(r_eff));
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[QUOT_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
		end else if (mode_q == 2'd2) begin
			if (rv_q >= trial) begin
				rv_q <= rv_q - trial;
				rres_q <= (rres_q >> 1) + rbit_q;
			end else begin
				rres_q <= rres_q >> 1;
			end
			rbit_q <= rbit_q >> 2;
		end
		if (cmd.size_latch) begin
			w_q <= WID_W'((rres_q[ROOT_W-1:7] + 16'd1) >> 1);
		end
		if (mstep_q == 2'd1) h_q <= HGT_W'((wr + 28'd128) >> 8);
		if (mstep_q == 2'd2) begin
			px_q <= (WID_W+SCALE_W)'(w_q) * (WID_W+SCALE_W)'(scale);
			py_q <= (HGT_W+SCALE_W)'(h_q) * (HGT_W+SCALE_W)'(scale);
		end
	end

	assign sts.div_done = (mode_q == 2'd1) && (cnt_q == 6'd1);
	assign sts.sqrt_done = (mode_q == 2'd2) && (cnt_q == 6'd1);
	assign sts.mul_done = (mstep_q == 2'd3);

	assign cen = 37'(base_q - 11'd1) * 37'sd256;
	assign hx = $signed(37'(px_q)) - 37'sd256;
	assign hy = $signed(37'(py_q)) - 37'sd256;

	function automatic logic [COORD_W-1:0] sat(input logic signed [36:0] v);
		if (v > 37'sh7FFFFFFF) return 32'h7FFFFFFF;
		if (v < -37'sh80000000) return 32'h80000000;
		return v[COORD_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			left <= sat(cen - hx);
			right <= sat(cen + hx);
			top <= sat(cen - hy);
			bottom <= sat(cen + hy);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/dag_ctrl.sv =====
// dag_ctrl: sequencer over ratios and scales, output handshake
// depends on dag_pkg
`default_nettype none
module dag_ctrl #(
	parameter int MAX_RATIOS = 3,
	parameter int MAX_SCALES = 3
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] ratio_count,
	input wire logic [1:0] scale_count,
	output dag_pkg::dag_cmd_t cmd,
	input wire dag_pkg::dag_sts_t sts,
	output logic [1:0] ratio_step,
	output logic [1:0] scale_step,
	output logic out_valid,
	input wire logic out_ready,
	output logic [dag_pkg::BOXNUM_W-1:0] box_number,
	output logic final_box
);
	import dag_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_SQRT = 3'd2;
	localparam logic [2:0] ST_SIZE = 3'd3;
	localparam logic [2:0] ST_MUL = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;
	localparam logic [2:0] ST_START = 3'd6;
	localparam logic [2:0] ST_ROOT = 3'd7;

	logic [2:0] state_q;
	logic [1:0] ri_q, si_q, nr_q, ns_q, nr_c, ns_c;
	logic last_s, last_r;

	always_comb begin
		nr_c = (ratio_count == 2'd0) ? 2'd1 : ratio_count;
		ns_c = (scale_count == 2'd0) ? 2'd1 : scale_count;
		if (nr_c > 2'(MAX_RATIOS)) nr_c = 2'(MAX_RATIOS);
		if (ns_c > 2'(MAX_SCALES)) ns_c = 2'(MAX_SCALES);
	end

	assign last_s = (si_q + 2'd1 == ns_q);
	assign last_r = (ri_q + 2'd1 == nr_q);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign ratio_step = ri_q;
	assign scale_step = si_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.div_start = (state_q == ST_START);
		cmd.sqrt_start = (state_q == ST_ROOT);
		cmd.size_latch = (state_q == ST_SIZE);
		cmd.emit = (state_q == ST_MUL) && sts.mul_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ri_q <= '0;
			si_q <= '0;
			nr_q <= 2'd1;
			ns_q <= 2'd1;
			box_number <= '0;
			final_box <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd.load) begin
					ri_q <= '0;
					si_q <= '0;
					nr_q <= nr_c;
					ns_q <= ns_c;
					box_number <= '0;
					state_q <= ST_START;
				end
				ST_START: state_q <= ST_DIV;
				ST_DIV: if (sts.div_done) state_q <= ST_ROOT;
				ST_ROOT: state_q <= ST_SQRT;
				ST_SQRT: if (sts.sqrt_done) state_q <= ST_SIZE;
				ST_SIZE: state_q <= ST_MUL;
				ST_MUL: if (sts.mul_done) begin
					final_box <= last_s && last_r;
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) begin
					box_number <= box_number + 4'd1;
					if (!last_s) begin
						si_q <= si_q + 2'd1;
						state_q <= ST_SIZE;
					end else if (!last_r) begin
						si_q <= '0;
						ri_q <= ri_q + 2'd1;
						state_q <= ST_START;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/dag_regs.sv =====
// dag_regs: APB register file for counts, ratios and scales
// depends on dag_pkg
`default_nettype none
module dag_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	input wire logic [1:0] ratio_sel,
	input wire logic [1:0] scale_sel,
	output logic [1:0] ratio_count,
	output logic [1:0] scale_count,
	output logic [dag_pkg::RATIO_W-1:0] ratio,
	output logic [dag_pkg::SCALE_W-1:0] scale
);
	import dag_pkg::*;

	logic [RATIO_W-1:0] ra_q, rb_q, rc_q;
	logic [SCALE_W-1:0] sa_q, sb_q, sc_q;
	logic [2:0] idx;

	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_count <= 2'd3;
			scale_count <= 2'd3;
			ra_q <= 12'd128;
			rb_q <= 12'd256;
			rc_q <= 12'd512;
			sa_q <= 16'd2048;
			sb_q <= 16'd4096;
			sc_q <= 16'd8192;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			unique case (idx)
				REG_RATIO_COUNT: ratio_count <= pwdata[1:0];
				REG_SCALE_COUNT: scale_count <= pwdata[1:0];
				REG_RATIO_A: ra_q <= pwdata[RATIO_W-1:0];
				REG_RATIO_B: rb_q <= pwdata[RATIO_W-1:0];
				REG_RATIO_C: rc_q <= pwdata[RATIO_W-1:0];
				REG_SCALE_A: sa_q <= pwdata[SCALE_W-1:0];
				REG_SCALE_B: sb_q <= pwdata[SCALE_W-1:0];
				REG_SCALE_C: sc_q <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RATIO_COUNT: prdata = 32'(ratio_count);
			REG_SCALE_COUNT: prdata = 32'(scale_count);
			REG_RATIO_A: prdata = 32'(ra_q);
			REG_RATIO_B: prdata = 32'(rb_q);
			REG_RATIO_C: prdata = 32'(rc_q);
			REG_SCALE_A: prdata = 32'(sa_q);
			REG_SCALE_B: prdata = 32'(sb_q);
			REG_SCALE_C: prdata = 32'(sc_q);
			default: prdata = '0;
		endcase
		unique case (ratio_sel)
			2'd0: ratio = ra_q;
			2'd1: ratio = rb_q;
			default: ratio = rc_q;
		endcase
		unique case (scale_sel)
			2'd0: scale = sa_q;
			2'd1: scale = sb_q;
			default: scale = sc_q;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/detection_anchor_generator.sv =====
// detection_anchor_generator: top level, anchor boxes for one base size per transaction
// depends on dag_pkg, dag_regs, dag_ctrl, dag_datapath
//
// s_axis takes one base size per transaction (tdata bits 10:0). m_axis gives
// ratio_count * scale_count boxes, ratio outer and scale inner, with tlast on
// the final box. Registers are to be written over the APB port while idle; the
// block itself does not enforce this. Per ratio a shared iterative unit runs a
// 46-step restoring division and a 24-step square root, each launched from its
// own state; each box then takes the SIZE and MUL states for multiplies and
// corner forming, plus the output handshake.
// A full run gives at most nine boxes. One base size is worked at a time: after
// the last box the sequencer returns to idle, and s_axis_tready stays low until
// the last box is taken.
// When m_axis_tready is low the box holds and the sequencer waits.
// Reset restores the default ratios 0.5, 1, 2 and scales 8, 16, 32 and
// returns the sequencer to idle.
`default_nettype none
module detection_anchor_generator #(
	parameter int MAX_RATIOS = 3,
	parameter int MAX_SCALES = 3
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [15:0] s_axis_tdata, // box side
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [135:0] m_axis_tdata, // left, top, right, bottom, box_number
	output logic m_axis_tlast, // final_box
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import dag_pkg::*;

	dag_cmd_t cmd;
	dag_sts_t sts;
	logic [1:0] ratio_count, scale_count, ratio_step, scale_step;
	logic [RATIO_W-1:0] ratio;
	logic [SCALE_W-1:0] scale;
	logic [BASE_W-1:0] base_q;
	logic [COORD_W-1:0] left, top, right, bottom;
	logic [BOXNUM_W-1:0] box_number;

	assign pready = 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) base_q <= (s_axis_tdata[BASE_W-1:0] == '0) ? BASE_W'(1)
			: s_axis_tdata[BASE_W-1:0];
	end

	dag_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.ratio_sel(ratio_step), .scale_sel(scale_step),
		.ratio_count, .scale_count, .ratio, .scale
	);

	dag_ctrl #(.MAX_RATIOS(MAX_RATIOS), .MAX_SCALES(MAX_SCALES)) u_ctrl (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.ratio_count, .scale_count, .cmd, .sts, .ratio_step, .scale_step,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.box_number, .final_box(m_axis_tlast)
	);

	dag_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .base_q, .ratio, .scale,
		.left, .top, .right, .bottom
	);

	assign m_axis_tdata = {4'd0, box_number, bottom, right, top, left};
endmodule
`default_nettype wire

// ===== tb/dag_checker.sv =====
// dag_checker: watches the base size and box streams of the anchor generator,
// predicts every box from the register settings it observes and compares them
// depends on dag_pkg
`default_nettype none
module dag_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [15:0] s_axis_tdata,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [135:0] m_axis_tdata,
	input wire logic m_axis_tlast,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic pready,
	output int fail_count,
	output int pending_boxes,
	output int boxes_seen
);
	import dag_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
		logic [BOXNUM_W-1:0] box_number;
		logic final_box;
	} anchor_box_t;

	anchor_box_t anchor_q[$];
	logic [1:0] ratio_count, scale_count;
	logic [RATIO_W-1:0] ratio_reg[3];
	logic [SCALE_W-1:0] scale_reg[3];

	assign pending_boxes = anchor_q.size();

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	task automatic predict_anchors(input logic [BASE_W-1:0] base_in);
		longint b, centre, hx, hy;
		logic [63:0] r, q, w, h, s;
		int nr, ns;
		anchor_box_t bx;
		b = base_in;
		if (b == 0) b = 1;
		nr = (ratio_count == 0) ? 1 : ratio_count;
		ns = (scale_count == 0) ? 1 : scale_count;
		centre = (b - 1) * 256;
		for (int i = 0; i < nr; i++) begin
			r = ratio_reg[i];
			if (r == 0) r = 1;
			q = ((b * b) << 24) / r;
			w = ((int_sqrt(q) >> 7) + 1) >> 1;
			h = (w * r + 128) >> 8;
			for (int j = 0; j < ns; j++) begin
				s = scale_reg[j];
				hx = longint'(w * s) - 256;
				hy = longint'(h * s) - 256;
				bx.left = clamp32(centre - hx);
				bx.top = clamp32(centre - hy);
				bx.right = clamp32(centre + hx);
				bx.bottom = clamp32(centre + hy);
				bx.box_number = BOXNUM_W'(i * ns + j);
				bx.final_box = (i + 1 == nr) && (j + 1 == ns);
				anchor_q.push_back(bx);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		anchor_box_t want;
		if (!arst_n) begin
			ratio_count <= 2'd3;
			scale_count <= 2'd3;
			ratio_reg <= '{12'd128, 12'd256, 12'd512};
			scale_reg <= '{16'd2048, 16'd4096, 16'd8192};
			anchor_q.delete();
			fail_count = 0;
			boxes_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_RATIO_COUNT: ratio_count <= pwdata[1:0];
					REG_SCALE_COUNT: scale_count <= pwdata[1:0];
					REG_RATIO_A: ratio_reg[0] <= pwdata[11:0];
					REG_RATIO_B: ratio_reg[1] <= pwdata[11:0];
					REG_RATIO_C: ratio_reg[2] <= pwdata[11:0];
					REG_SCALE_A: scale_reg[0] <= pwdata[15:0];
					REG_SCALE_B: scale_reg[1] <= pwdata[15:0];
					REG_SCALE_C: scale_reg[2] <= pwdata[15:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_anchors(s_axis_tdata[BASE_W-1:0]);
			if (m_axis_tvalid && m_axis_tready) begin
				boxes_seen <= boxes_seen + 1;
				if (anchor_q.size() == 0) begin
					report_mismatch("unexpected box", m_axis_tdata[31:0], 32'd0);
				end else begin
					want = anchor_q.pop_front();
					if (m_axis_tdata[31:0] !== want.left)
						report_mismatch("left", m_axis_tdata[31:0], want.left);
					if (m_axis_tdata[63:32] !== want.top)
						report_mismatch("top", m_axis_tdata[63:32], want.top);
					if (m_axis_tdata[95:64] !== want.right)
						report_mismatch("right", m_axis_tdata[95:64], want.right);
					if (m_axis_tdata[127:96] !== want.bottom)
						report_mismatch("bottom", m_axis_tdata[127:96], want.bottom);
					if (m_axis_tdata[131:128] !== want.box_number)
						report_mismatch("box_number", 32'(m_axis_tdata[131:128]),
							32'(want.box_number));
					if (m_axis_tdata[135:132] !== 4'd0)
						report_mismatch("tdata padding", 32'(m_axis_tdata[135:132]),
							32'd0);
					if (m_axis_tlast !== want.final_box)
						report_mismatch("tlast", 32'(m_axis_tlast), 32'(want.final_box));
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb_detection_anchor_generator.sv =====
// tb_detection_anchor_generator: drives base sizes and register settings into
// the anchor generator with random idling; depends on dag_pkg, dag_checker
`default_nettype none
module tb_detection_anchor_generator;
	import dag_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [135:0] m_axis_tdata;
	logic m_axis_tlast;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	int fail_count, pending_boxes, boxes_seen;
	int sizes_sent = 0;
	int stall_cycles = 0;
	bit calm = 0;

	always #1 clk = ~clk;

	detection_anchor_generator dut (.*);
	dag_checker checker_i (.*);

	// watchdog on cycles with no transaction on either stream
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 20000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// box sink with bursts of back-pressure
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 0;
				hold = $urandom_range(1, 12);
				repeat (hold) @(negedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_size(input logic [BASE_W-1:0] base);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {5'd0, base};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		s_axis_tvalid <= 0;
		sizes_sent++;
	endtask

	task automatic drain_boxes;
		while (pending_boxes != 0 || s_axis_tvalid) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_settings(input bit extremes);
		write_reg(REG_RATIO_COUNT, $urandom_range(0, 3));
		write_reg(REG_SCALE_COUNT, $urandom_range(0, 3));
		write_reg(REG_RATIO_A, extremes ? 32'd4095 : $urandom_range(0, 4095));
		write_reg(REG_RATIO_B, extremes ? 32'd1 : $urandom_range(0, 4095));
		write_reg(REG_RATIO_C, $urandom_range(0, 4095));
		write_reg(REG_SCALE_A, extremes ? 32'd65535 : $urandom_range(0, 65535));
		write_reg(REG_SCALE_B, extremes ? 32'd1 : $urandom_range(0, 65535));
		write_reg(REG_SCALE_C, $urandom_range(0, 65535));
	endtask

	function automatic logic [BASE_W-1:0] pick_size();
		case ($urandom_range(0, 5))
			0: return BASE_W'($urandom_range(0, 2047));
			1: return BASE_W'($urandom_range(0, 8));
			default: return BASE_W'($urandom_range(1, 1024));
		endcase
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// reset defaults with edge base sizes
		send_size(0);
		send_size(1);
		send_size(16);
		send_size(1024);
		send_size(2047);
		send_size(11'h555);
		send_size(11'h2aa);
		drain_boxes();
		// extremes of ratios and scales, zero ratio and zero scale
		write_reg(REG_RATIO_COUNT, 3);
		write_reg(REG_SCALE_COUNT, 3);
		write_reg(REG_RATIO_A, 4095);
		write_reg(REG_RATIO_B, 1);
		write_reg(REG_RATIO_C, 0);
		write_reg(REG_SCALE_A, 65535);
		write_reg(REG_SCALE_B, 0);
		write_reg(REG_SCALE_C, 1);
		send_size(1);
		send_size(2047);
		send_size(1024);
		send_size(3);
		drain_boxes();
		// zero counts act as one, single box runs, then runs of one ratio and two scales
		write_reg(REG_RATIO_COUNT, 0);
		write_reg(REG_SCALE_COUNT, 0);
		send_size(0);
		send_size(700);
		drain_boxes();
		write_reg(REG_RATIO_COUNT, 1);
		write_reg(REG_SCALE_COUNT, 2);
		send_size(37);
		send_size(2047);
		drain_boxes();
		// random phases, each with fresh settings
		for (int ph = 0; ph < 8; ph++) begin
			random_settings(ph == 0);
			if (ph == 7) calm = 1;
			repeat (19) send_size(pick_size());
			drain_boxes();
		end
		$display("base sizes sent: %0d, boxes checked: %0d", sizes_sent, boxes_seen);
		$display("covered default, extreme and random ratio and scale settings");
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
